// ===== hw/rtl/two_level_priority_rr_scheduler_defines.svh =====
// Assertion macros used by the scheduler control FSM.
`ifndef TWO_LEVEL_PRIORITY_RR_SCHEDULER_DEFINES_SVH
`define TWO_LEVEL_PRIORITY_RR_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TLPRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TLPRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tlprs_pkg.sv =====
package tlprs_pkg;

  localparam int NSLOT = 16;
  localparam int SW    = $clog2(NSLOT);
  localparam int CW    = SW + 1;

  localparam logic [2:0] ST_RUN1 = 3'd0;
  localparam logic [2:0] ST_RUN2 = 3'd1;
  localparam logic [2:0] ST_IDLE = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_DROP = 3'd4;

  typedef logic [SW-1:0] slot_t;

  typedef struct packed {
    logic load;
    logic arr;
    logic scan;
    logic ins;
    logic tick;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic scan_hit;
  } dp_stat_t;

endpackage

// ===== hw/rtl/two_level_priority_rr_scheduler.sv =====
// Channel  Handshake              Payload
// in       in_valid / in_ready    in_kind, in_task_id, in_urgency, in_burst_len
// out      out_valid / out_ready  out_status .. out_waiting
// cfg      cfg_valid / cfg_ready  cfg_quantum
// A tick request passes through the tick and finish states before the output handshake.
// An arrival passes through the arrival, scan and insert states; the scan walks the level
// one entries of the sorted insert (up to 15), one entry per cycle through the slot
// urgency read; a dropped arrival goes from the arrival state straight to the output.
// Reset is synchronous and active low; no clearing pass is needed.
// A new request is taken only after the previous result has been taken.
module two_level_priority_rr_scheduler import tlprs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_task_id,
  input  logic [7:0]  in_urgency,
  input  logic [15:0] in_burst_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_run_id,
  output logic        out_finished,
  output logic        out_demoted,
  output logic [31:0] out_finish_time,
  output logic [31:0] out_turnaround,
  output logic [31:0] out_waiting,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_quantum
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  tlprs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlprs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_valid       (cfg_valid),
    .cfg_quantum     (cfg_quantum),
    .in_task_id      (in_task_id),
    .in_urgency      (in_urgency),
    .in_burst_len    (in_burst_len),
    .out_status      (out_status),
    .out_run_id      (out_run_id),
    .out_finished    (out_finished),
    .out_demoted     (out_demoted),
    .out_finish_time (out_finish_time),
    .out_turnaround  (out_turnaround),
    .out_waiting     (out_waiting)
  );

endmodule

// ===== hw/rtl/tlprs_dp.sv =====
module tlprs_dp import tlprs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        cfg_valid,
  input  logic [7:0]  cfg_quantum,
  input  logic [7:0]  in_task_id,
  input  logic [7:0]  in_urgency,
  input  logic [15:0] in_burst_len,
  output logic [2:0]  out_status,
  output logic [7:0]  out_run_id,
  output logic        out_finished,
  output logic        out_demoted,
  output logic [31:0] out_finish_time,
  output logic [31:0] out_turnaround,
  output logic [31:0] out_waiting
);

  logic [7:0]  slot_id_r    [NSLOT];
  logic [7:0]  slot_urg_r   [NSLOT];
  logic [15:0] slot_rem_r   [NSLOT];
  logic [15:0] slot_burst_r [NSLOT];
  logic [31:0] slot_arr_r   [NSLOT];
  slot_t       uord_r       [NSLOT];
  slot_t       lring_r      [NSLOT];

  logic [NSLOT-1:0] free_r;
  logic [CW-1:0]    ucnt_r, lcnt_r, scan_i_r;
  slot_t            lhead_r, new_slot_r;
  logic [31:0]      now_r;
  logic [7:0]       slice_r, quantum_r;
  logic             lrun_r, ran_last_r;

  logic [7:0]  id_r, urg_r;
  logic [15:0] burst_r, burst_hold_r;
  logic [2:0]  res_status_r;
  logic [7:0]  res_id_r;
  logic        res_fin_r, res_dem_r;
  logic [31:0] res_ft_r, res_tat_r, res_wait_r;

  slot_t       free_idx, head_slot, scan_slot, lo_slot, run_slot, push_idx;
  logic        demote, use_up, use_lo, done;
  logic [15:0] rem;
  logic [31:0] now_inc;
  logic [7:0]  slice_nxt;

  always_comb begin
    free_idx = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        free_idx = slot_t'(i);
      end
    end
  end

  assign head_slot = uord_r[0];
  assign scan_slot = uord_r[scan_i_r[SW-1:0]];
  assign lo_slot   = lring_r[lhead_r];
  assign push_idx  = lhead_r + lcnt_r[SW-1:0];
  assign demote    = ran_last_r && (ucnt_r != '0) && (urg_r < slot_urg_r[head_slot]);
  assign use_up    = !lrun_r && (ucnt_r != '0);
  assign use_lo    = !use_up && (lcnt_r != '0);
  assign run_slot  = use_up ? head_slot : lo_slot;
  assign rem       = slot_rem_r[run_slot];
  assign done      = rem <= 16'd1;
  assign now_inc   = now_r + 32'd1;
  assign slice_nxt = (lrun_r ? slice_r : 8'd0) + 8'd1;

  assign stat.full     = (free_r == '0);
  assign stat.scan_hit = (scan_i_r == ucnt_r) || (slot_urg_r[scan_slot] > urg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r     <= '1;
      ucnt_r     <= '0;
      lcnt_r     <= '0;
      lhead_r    <= '0;
      now_r      <= '0;
      slice_r    <= '0;
      lrun_r     <= 1'b0;
      ran_last_r <= 1'b0;
      quantum_r  <= 8'd2;
      scan_i_r   <= '0;
    end else begin
      if (cfg_valid) begin
        quantum_r <= cfg_quantum;
      end
      if (cmd.arr && !stat.full) begin
        if (demote) begin
          ran_last_r <= 1'b0;
          ucnt_r     <= ucnt_r - CW'(1);
          if (!lcnt_r[SW]) begin
            lcnt_r <= lcnt_r + CW'(1);
          end
        end
        free_r[free_idx] <= 1'b0;
        scan_i_r         <= '0;
      end
      if (cmd.scan && !stat.scan_hit) begin
        scan_i_r <= scan_i_r + CW'(1);
      end
      if (cmd.ins && !ucnt_r[SW]) begin
        ucnt_r <= ucnt_r + CW'(1);
      end
      if (cmd.tick) begin
        ran_last_r <= 1'b0;
        if (use_up) begin
          now_r <= now_inc;
          if (done) begin
            free_r[run_slot] <= 1'b1;
            ucnt_r           <= ucnt_r - CW'(1);
          end else begin
            ran_last_r <= 1'b1;
          end
        end else if (use_lo) begin
          now_r   <= now_inc;
          slice_r <= slice_nxt;
          if (done) begin
            free_r[run_slot] <= 1'b1;
            lhead_r          <= lhead_r + slot_t'(1);
            lcnt_r           <= lcnt_r - CW'(1);
            lrun_r           <= 1'b0;
          end else if (slice_nxt >= quantum_r) begin
            lhead_r <= lhead_r + slot_t'(1);
            lrun_r  <= 1'b0;
          end else begin
            lrun_r <= 1'b1;
          end
        end else begin
          now_r  <= now_inc;
          lrun_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r         <= in_task_id;
      urg_r        <= in_urgency;
      burst_r      <= in_burst_len;
      res_status_r <= ST_IDLE;
      res_id_r     <= '0;
      res_fin_r    <= 1'b0;
      res_dem_r    <= 1'b0;
      res_ft_r     <= '0;
      res_tat_r    <= '0;
      res_wait_r   <= '0;
      burst_hold_r <= '0;
    end
    if (cmd.arr) begin
      res_id_r <= id_r;
      if (stat.full) begin
        res_status_r <= ST_DROP;
      end else begin
        res_status_r <= ST_ACC;
        res_dem_r    <= demote;
        if (demote) begin
          for (int j = 0; j < NSLOT - 1; j++) begin
            uord_r[j] <= uord_r[j+1];
          end
          if (!lcnt_r[SW]) begin
            lring_r[push_idx] <= head_slot;
          end
        end
        slot_id_r[free_idx]    <= id_r;
        slot_urg_r[free_idx]   <= urg_r;
        slot_burst_r[free_idx] <= burst_r;
        slot_rem_r[free_idx]   <= burst_r;
        slot_arr_r[free_idx]   <= now_r;
        new_slot_r             <= free_idx;
      end
    end
    if (cmd.ins && !ucnt_r[SW]) begin
      if (scan_i_r == '0) begin
        uord_r[0] <= new_slot_r;
      end
      for (int j = 1; j < NSLOT; j++) begin
        if (CW'(j) == scan_i_r) begin
          uord_r[j] <= new_slot_r;
        end else if (CW'(j) > scan_i_r) begin
          uord_r[j] <= uord_r[j-1];
        end
      end
    end
    if (cmd.tick && (use_up || use_lo)) begin
      res_status_r <= use_up ? ST_RUN1 : ST_RUN2;
      res_id_r     <= slot_id_r[run_slot];
      if (done) begin
        slot_rem_r[run_slot] <= '0;
        res_fin_r            <= 1'b1;
        res_ft_r             <= now_inc;
        res_tat_r            <= now_inc - slot_arr_r[run_slot];
        burst_hold_r         <= slot_burst_r[run_slot];
        if (use_up) begin
          for (int j = 0; j < NSLOT - 1; j++) begin
            uord_r[j] <= uord_r[j+1];
          end
        end
      end else begin
        slot_rem_r[run_slot] <= rem - 16'd1;
        if (!use_up && slice_nxt >= quantum_r) begin
          lring_r[push_idx] <= run_slot;
        end
      end
    end
    if (cmd.fin) begin
      res_wait_r <= res_fin_r ? (res_tat_r - {16'd0, burst_hold_r}) : 32'd0;
    end
  end

  assign out_status      = res_status_r;
  assign out_run_id      = res_id_r;
  assign out_finished    = res_fin_r;
  assign out_demoted     = res_dem_r;
  assign out_finish_time = res_ft_r;
  assign out_turnaround  = res_tat_r;
  assign out_waiting     = res_wait_r;

endmodule

// ===== hw/rtl/tlprs_ctrl.sv =====
`include "two_level_priority_rr_scheduler_defines.svh"

module tlprs_ctrl import tlprs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_kind,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ARR  = 7'b0000010,
    S_SCAN = 7'b0000100,
    S_INS  = 7'b0001000,
    S_TICK = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = in_kind ? S_TICK : S_ARR;
        end
      end
      S_ARR: begin
        cmd.arr   = 1'b1;
        state_nxt = stat.full ? S_OUT : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_hit) begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        cmd.ins   = 1'b1;
        state_nxt = S_OUT;
      end
      S_TICK: begin
        cmd.tick  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TLPRS_ASSERT_NOW(a_excl, in_ready, !out_valid, "accept and result overlap")
  `TLPRS_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "accepted twice in a row")
  `TLPRS_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid, "result dropped")

endmodule
